/* rtl/apndic_pkg.sv */
// ============================================================================
// APN degree checker package
// Shared types and constants of the incremental APN and degree checker.
// ============================================================================
package apndic_pkg;

	// Default S-box width in bits.
	localparam int BITS_DEFAULT = 8;

	// Width of the degree bound register and its value after reset.
	localparam int DEG_W = 3;
	localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd2;

	// Difference table counters are three bits wide and saturate.
	localparam int DIFF_W = 3;
	localparam logic [DIFF_W-1:0] DIFF_MAX = 3'd7;
	localparam logic [DIFF_W-1:0] DIFF_STEP = 3'd2;
	localparam logic [DIFF_W-1:0] DIFF_ADD_LIMIT = 3'd6;

	// Item kinds.
	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_DIFF,
		ST_CUBE,
		ST_DONE
	} state_t;

endpackage

/* rtl/apn_degree_incremental_checker.sv */
// ============================================================================
// APN degree incremental checker
// Keeps a partial S-box in memory and checks the APN property and the
// algebraic degree bound each time a point is added or removed.
// ============================================================================
//
// Usage. A word is issued by raising start while busy is low; kind selects an
// add or a remove, position and value give the point. The block answers every
// word with exactly one result: done is high for one cycle and ok is valid in
// that same cycle. The receiver cannot hold results off, and none is needed,
// since only one word is in flight and done is a single cycle pulse.
//
// Timing. An add runs a difference walk of 2^(BITS-1) - 1 steps followed by a
// cube walk over the 2^(BITS - weight(position)) supersets of the position.
// Both walks are pipelined through the memories, one step issued per cycle;
// the difference walk drains through its s1 and s2 stages and the cube walk
// through its s1 stage. A remove first passes through a lookup state and
// ends there if the position is undefined. A walk that fails ends early.
// The registered memory reads, one per dependent lookup, set the drain
// length.
//
// Reset. After arst_n is released the block runs a clearing pass over all
// 2^(2*BITS) difference table addresses (65536 at BITS = 8) that zeroes the difference table,
// the cube counters and the defined flags; busy stays high during the pass.
// The degree bound register may be written at any time through cfg_we and
// cfg_data but is meant to change only while the block is idle.
//
module apn_degree_incremental_checker
	import apndic_pkg::*;
#(
	parameter int BITS = BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DEG_W-1:0] cfg_data,
	input  logic             start,
	output logic             busy,
	input  logic             kind,
	input  logic [7:0]       position,
	input  logic [7:0]       value,
	output logic             done,
	output logic             ok
);

	localparam int DEPTH = 1 << BITS;
	localparam int DIFF_DEPTH = 1 << (2 * BITS);
	localparam int CNT_W = BITS + 1;
	localparam int WGT_W = $clog2(BITS + 1);
	localparam int CMP_W = WGT_W + DEG_W;
	localparam int B_W = BITS - 1;
	localparam logic [CNT_W-1:0] CUBE_MAX = '1;

	// Point memory holds a defined flag on top of the stored value.
	logic [BITS:0] pt_mem [DEPTH];
	logic [DIFF_W-1:0] df_mem [DIFF_DEPTH];
	// Cube memory holds the point count on top of the running XOR.
	logic [CNT_W+BITS-1:0] cb_mem [DEPTH];

	state_t state_q, state_d;

	logic [2*BITS-1:0] clr_q;
	logic [DEG_W-1:0] degree_bound_q;
	logic ok_q;

	// Latched item.
	logic kind_q;
	logic [BITS-1:0] c_q;
	logic [BITS-1:0] v_q;

	// Difference walk: the counter runs over the upper bits of the even-weight
	// differences, the low bit is the parity that makes the weight even.
	logic [B_W-1:0] b_q;
	logic d_issue_q;
	logic [BITS-1:0] d_a;
	logic d_vld_s1;
	logic [BITS-1:0] d_a_s1;
	logic d_vld_s2;
	logic [2*BITS-1:0] d_addr_s2;
	logic [2*BITS-1:0] d_raddr;
	logic [DIFF_W-1:0] d_new;
	logic d_fail;
	logic d_drained;

	// Cube walk over the supersets of the position.
	logic [BITS-1:0] cu_u_q;
	logic cu_issue_q;
	logic [WGT_W-1:0] cu_wgt;
	logic cu_check;
	logic c_vld_s1;
	logic [BITS-1:0] c_u_s1;
	logic [CNT_W-1:0] c_full_s1;
	logic [CNT_W-1:0] c_cnt_new;
	logic [BITS-1:0] c_xor_new;
	logic c_fail;
	logic c_drained;

	// Memory ports.
	logic [BITS-1:0] pt_raddr;
	logic [BITS:0] pt_rd_q;
	logic pt_we;
	logic [BITS-1:0] pt_waddr;
	logic [BITS:0] pt_wdata;
	logic [DIFF_W-1:0] df_rd_q;
	logic df_we;
	logic [2*BITS-1:0] df_waddr;
	logic [DIFF_W-1:0] df_wdata;
	logic [CNT_W+BITS-1:0] cb_rd_q;
	logic cb_we;
	logic [BITS-1:0] cb_waddr;
	logic [CNT_W+BITS-1:0] cb_wdata;

	logic accept;
	logic [BITS-1:0] pos_in;
	logic [BITS-1:0] val_in;

	assign accept = start && (state_q == ST_IDLE);
	assign pos_in = BITS'(position);
	assign val_in = BITS'(value);

	// ------------------------------------------------------------------
	// Difference walk datapath.
	// ------------------------------------------------------------------
	assign d_a = {b_q, ^b_q};
	assign d_raddr = {d_a_s1, v_q ^ pt_rd_q[BITS-1:0]};
	assign d_drained = !d_issue_q && !d_vld_s1 && !d_vld_s2;

	always_comb begin
		if (kind_q == KIND_ADD) begin
			d_new = (df_rd_q < DIFF_ADD_LIMIT) ? df_rd_q + DIFF_STEP : DIFF_MAX;
			d_fail = d_new > DIFF_STEP;
		end else begin
			d_new = (df_rd_q >= DIFF_STEP) ? df_rd_q - DIFF_STEP : '0;
			d_fail = d_new == DIFF_STEP;
		end
		d_fail = d_fail && d_vld_s2 && (state_q == ST_DIFF);
	end

	// ------------------------------------------------------------------
	// Cube walk datapath.
	// ------------------------------------------------------------------
	always_comb begin
		cu_wgt = '0;
		for (int i = 0; i < BITS; i++) begin
			cu_wgt = cu_wgt + WGT_W'(cu_u_q[i]);
		end
	end

	assign cu_check = CMP_W'(cu_wgt) > CMP_W'(degree_bound_q);
	assign c_drained = !cu_issue_q && !c_vld_s1;

	always_comb begin
		logic [CNT_W-1:0] cnt;
		cnt = cb_rd_q[CNT_W+BITS-1:BITS];
		c_xor_new = cb_rd_q[BITS-1:0] ^ v_q;
		if (kind_q == KIND_ADD) begin
			c_cnt_new = (cnt != CUBE_MAX) ? cnt + CNT_W'(1) : cnt;
			c_fail = (c_cnt_new == c_full_s1) && (c_xor_new != '0);
		end else begin
			c_cnt_new = (cnt != '0) ? cnt - CNT_W'(1) : '0;
			c_fail = (c_cnt_new == c_full_s1 - CNT_W'(1)) && (c_xor_new != v_q);
		end
		c_fail = c_fail && c_vld_s1 && (state_q == ST_CUBE);
	end

	// ------------------------------------------------------------------
	// Sequencer: next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = (kind == KIND_ADD) ? ST_DIFF : ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = pt_rd_q[BITS] ? ST_DIFF : ST_DONE;
			end
			ST_DIFF: begin
				if (d_fail) begin
					state_d = ST_DONE;
				end else if (d_drained) begin
					state_d = ST_CUBE;
				end
			end
			ST_CUBE: begin
				if (c_fail || c_drained) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs and memory write ports.
	// ------------------------------------------------------------------
	always_comb begin
		busy = state_q != ST_IDLE;
		done = state_q == ST_DONE;
		pt_raddr = c_q ^ d_a;
		pt_we = 1'b0;
		pt_waddr = c_q;
		pt_wdata = {1'b0, v_q};
		df_we = 1'b0;
		df_waddr = d_addr_s2;
		df_wdata = d_new;
		cb_we = 1'b0;
		cb_waddr = c_u_s1;
		cb_wdata = {c_cnt_new, c_xor_new};
		unique case (state_q)
			ST_CLEAR: begin
				pt_we = 1'b1;
				pt_waddr = clr_q[BITS-1:0];
				pt_wdata = '0;
				df_we = 1'b1;
				df_waddr = clr_q;
				df_wdata = '0;
				cb_we = 1'b1;
				cb_waddr = clr_q[BITS-1:0];
				cb_wdata = '0;
			end
			ST_IDLE: begin
				pt_raddr = pos_in;
				if (start && (kind == KIND_ADD)) begin
					pt_we = 1'b1;
					pt_waddr = pos_in;
					pt_wdata = {1'b1, val_in};
				end
			end
			ST_LOOKUP: begin
			end
			ST_DIFF: begin
				df_we = d_vld_s2;
			end
			ST_CUBE: begin
				cb_we = c_vld_s1;
			end
			ST_DONE: begin
				// A remove leaves the position undefined, whether it unwound or not.
				pt_we = kind_q == KIND_REMOVE;
			end
			default: begin
			end
		endcase
	end

	assign ok = ok_q;

	// ------------------------------------------------------------------
	// Memories: one write port and one registered read port each.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_waddr] <= pt_wdata;
		end
		pt_rd_q <= pt_mem[pt_raddr];
	end

	always_ff @(posedge clk) begin
		if (df_we) begin
			df_mem[df_waddr] <= df_wdata;
		end
		df_rd_q <= df_mem[d_raddr];
	end

	always_ff @(posedge clk) begin
		if (cb_we) begin
			cb_mem[cb_waddr] <= cb_wdata;
		end
		cb_rd_q <= cb_mem[cu_u_q];
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			degree_bound_q <= DEGREE_RESET;
			ok_q <= 1'b0;
			d_issue_q <= 1'b0;
			d_vld_s1 <= 1'b0;
			d_vld_s2 <= 1'b0;
			cu_issue_q <= 1'b0;
			c_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				degree_bound_q <= cfg_data;
			end
			if (accept) begin
				ok_q <= 1'b1;
			end else if (d_fail || c_fail) begin
				ok_q <= 1'b0;
			end else if ((state_q == ST_LOOKUP) && !pt_rd_q[BITS]) begin
				ok_q <= 1'b0;
			end
			if (state_q != ST_DIFF) begin
				d_issue_q <= state_d == ST_DIFF;
			end else begin
				d_issue_q <= d_issue_q && (b_q != '1) && (state_d == ST_DIFF);
			end
			d_vld_s1 <= (state_q == ST_DIFF) && d_issue_q;
			d_vld_s2 <= (state_q == ST_DIFF) && d_vld_s1 && pt_rd_q[BITS];
			if (state_q != ST_CUBE) begin
				cu_issue_q <= state_d == ST_CUBE;
			end else begin
				cu_issue_q <= cu_issue_q && (cu_u_q != '1) && (state_d == ST_CUBE);
			end
			c_vld_s1 <= (state_q == ST_CUBE) && cu_issue_q && cu_check;
		end
	end

	// ------------------------------------------------------------------
	// Payload and walk counters.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			c_q <= pos_in;
			v_q <= val_in;
		end else if (state_q == ST_LOOKUP) begin
			v_q <= pt_rd_q[BITS-1:0];
		end
		if (state_q != ST_DIFF) begin
			b_q <= B_W'(1);
		end else if (d_issue_q) begin
			b_q <= b_q + B_W'(1);
		end
		d_a_s1 <= d_a;
		d_addr_s2 <= d_raddr;
		if (state_q != ST_CUBE) begin
			cu_u_q <= c_q;
		end else if (cu_issue_q) begin
			cu_u_q <= (cu_u_q + BITS'(1)) | c_q;
		end
		c_u_s1 <= cu_u_q;
		c_full_s1 <= CNT_W'(1) << cu_wgt;
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not make the block busy");

	a_undefined_remove: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOOKUP) && !pt_rd_q[BITS]) |=> (done && !ok))
		else $error("remove of an undefined point did not fail at once");

	a_even_diff: assert property (@(posedge clk) disable iff (!arst_n)
		d_vld_s1 |-> ((d_a_s1 != '0) && !(^d_a_s1)))
		else $error("difference walk issued a zero or odd-weight difference");

endmodule

/* tb/apn_degree_incremental_checker_tb.sv */
// ============================================================================
// APN degree incremental checker testbench
// Sends add and remove words through the command port, rewrites the degree
// bound between phases and checks every ok bit against a local model of the
// point store, the difference table and the cube counters, or against the answer a directed row carries.
// ============================================================================
module apn_degree_incremental_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import apndic_pkg::*;

	// Run length: the directed plan, a pile-up on one position that drives
	// a cube counter into saturation, then random words up to the total.
	localparam int WORDS_TOTAL = 1400;
	localparam int PILE_UP_ADDS = 515;
	localparam int PHASE_WORDS = 110;
	localparam logic [8:0] CUBE_CEILING = 9'h1ff;

	// How a directed row is checked: typed in, or taken from the model.
	typedef enum logic [1:0] {
		BY_PREDICTOR,
		WANT_OK,
		WANT_NOT_OK
	} check_e;

	// A directed row either issues a word or rewrites the degree bound.
	typedef enum logic {
		ROW_WORD,
		ROW_BOUND
	} row_e;

	typedef struct packed {
		row_e act;
		logic kind;
		logic [7:0] pos;
		logic [7:0] val;
		check_e chk;
	} row_t;

	// Directed plan. A remove at an undefined position must answer with ok
	// low, and the very first add after reset has nothing to collide with,
	// so those rows carry their answer. Positions 0 to 7 receive the cube
	// map over GF(8), a quadratic permutation on three bits, so the weight
	// three cube completes with a zero sum. Then comes an overwrite of a
	// defined position, a bound of zero where every single-bit cube is
	// checked, and repeated adds at one position that push a difference
	// counter into saturation before a remove brings it down again.
	localparam row_t PLAN [24] = '{
		'{ROW_WORD,  KIND_REMOVE, 8'h00, 8'h00, WANT_NOT_OK},
		'{ROW_WORD,  KIND_ADD,    8'hff, 8'hff, WANT_OK},
		'{ROW_WORD,  KIND_REMOVE, 8'hff, 8'h5a, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h00, 8'h00, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h01, 8'h01, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h02, 8'h03, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h03, 8'h04, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h04, 8'h05, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h05, 8'h06, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h06, 8'h07, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h07, 8'h02, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h05, 8'h80, BY_PREDICTOR},
		'{ROW_BOUND, KIND_ADD,    8'h00, 8'h00, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h40, 8'h5a, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h80, 8'h00, BY_PREDICTOR},
		'{ROW_WORD,  KIND_REMOVE, 8'h80, 8'hff, BY_PREDICTOR},
		'{ROW_BOUND, KIND_ADD,    8'h00, 8'h07, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h03, 8'h0f, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h00, 8'h00, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h00, 8'h00, BY_PREDICTOR},
		'{ROW_WORD,  KIND_ADD,    8'h00, 8'h00, BY_PREDICTOR},
		'{ROW_WORD,  KIND_REMOVE, 8'h00, 8'h00, BY_PREDICTOR},
		'{ROW_WORD,  KIND_REMOVE, 8'hff, 8'hff, WANT_NOT_OK},
		'{ROW_BOUND, KIND_ADD,    8'h00, 8'h02, BY_PREDICTOR}
	};

	// Every input of the block is known from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [DEG_W-1:0] cfg_data = DEGREE_RESET;
	logic start = 1'b0;
	logic kind = KIND_ADD;
	logic [7:0] position = 8'd0;
	logic [7:0] value = 8'd0;
	logic busy;
	logic done;
	logic ok;

	// Local copy of the checker's stores and of its degree bound.
	logic [7:0] sb_value [256];
	bit sb_defined [256];
	logic [DIFF_W-1:0] pair_tally [65536];
	logic [8:0] cube_tally [256];
	logic [7:0] cube_sum [256];
	logic [DEG_W-1:0] bound_reg;

	// ok bits still to come, oldest first, and the positions added so far,
	// newest last, so that a run of adds can be unwound in reverse order.
	bit ok_due [$];
	logic [7:0] add_log [$];

	int faults = 0;
	int words_sent = 0;
	int burst_left = 0;

	apn_degree_incremental_checker #(
		.BITS(8)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.kind(kind),
		.position(position),
		.value(value),
		.done(done),
		.ok(ok)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Difference walk. Every nonzero even-weight difference is visited in
	// ascending order; where the partner position is defined, the count for
	// that difference and output difference moves by two. An add stops as
	// soon as a count passes two, a remove stops where the count lands back
	// on two, where the matching add stopped if it found the count at two.
	function automatic bit pair_walk(logic [7:0] pos, bit adding);
		logic [7:0] v;
		logic [7:0] diff;
		logic [7:0] partner;
		logic [15:0] slot;
		int a;
		v = sb_value[pos];
		for (a = 1; a < 256; a++) begin
			diff = a[7:0];
			partner = pos ^ diff;
			if ($countones(diff) % 2 != 0 || !sb_defined[partner])
				continue;
			slot = {diff, v ^ sb_value[partner]};
			if (adding) begin
				pair_tally[slot] = (pair_tally[slot] < DIFF_ADD_LIMIT) ?
					pair_tally[slot] + DIFF_STEP : DIFF_MAX;
				if (pair_tally[slot] > DIFF_STEP)
					return 1'b0;
			end else begin
				pair_tally[slot] = (pair_tally[slot] >= DIFF_STEP) ?
					pair_tally[slot] - DIFF_STEP : '0;
				if (pair_tally[slot] == DIFF_STEP)
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Cube walk over every superset mask of the position whose weight is
	// above the bound. A cube is complete when it holds 2^weight points and
	// must then sum to zero. Counters saturate and stop at zero.
	function automatic bit cube_walk(logic [7:0] pos, bit adding);
		logic [7:0] v;
		logic [7:0] mask;
		int u;
		int w;
		int whole;
		v = sb_value[pos];
		for (u = 0; u < 256; u++) begin
			mask = u[7:0];
			w = $countones(mask);
			whole = 1 << w;
			if (w < int'(bound_reg) + 1 || (pos & ~mask) != 8'd0)
				continue;
			cube_sum[mask] = cube_sum[mask] ^ v;
			if (adding) begin
				if (cube_tally[mask] != CUBE_CEILING)
					cube_tally[mask] = cube_tally[mask] + 9'd1;
				if (int'(cube_tally[mask]) == whole && cube_sum[mask] != 8'd0)
					return 1'b0;
			end else begin
				if (cube_tally[mask] != 9'd0)
					cube_tally[mask] = cube_tally[mask] - 9'd1;
				if (int'(cube_tally[mask]) == whole - 1 && cube_sum[mask] != v)
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Applies one accepted word to the local stores and returns its ok bit.
	function automatic bit predict_ok(logic k, logic [7:0] pos, logic [7:0] val);
		bit fine;
		if (k == KIND_ADD) begin
			sb_value[pos] = val;
			sb_defined[pos] = 1'b1;
			fine = pair_walk(pos, 1'b1);
			if (fine)
				fine = cube_walk(pos, 1'b1);
			return fine;
		end
		if (!sb_defined[pos])
			return 1'b0;
		fine = pair_walk(pos, 1'b0);
		if (fine)
			fine = cube_walk(pos, 1'b0);
		sb_defined[pos] = 1'b0;
		return fine;
	endfunction

	// Presents one word and holds it until the block takes it. The word is
	// taken at the edge where start is high and busy is low; busy is read
	// before the block updates it, so the test matches what the block saw.
	// start is left high, so a following word goes out back to back.
	task automatic issue_word(logic k, logic [7:0] pos, logic [7:0] val, check_e chk);
		bit want;
		start <= 1'b1;
		kind <= k;
		position <= pos;
		value <= val;
		do @(posedge clk); while (busy);
		want = predict_ok(k, pos, val);
		if (chk == WANT_OK)
			want = 1'b1;
		else if (chk == WANT_NOT_OK)
			want = 1'b0;
		ok_due.push_back(want);
		if (k == KIND_ADD)
			add_log.push_back(pos);
		words_sent++;
	endtask

	// Sender pacing: words go out in bursts. Most gaps are short and land
	// while the block is still walking; about one in four is long enough
	// that the block has often gone idle before the next word shows up. Now and
	// then a long burst runs with no gap at all.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		if ($urandom_range(0, 5) == 0) begin
			burst_left = $urandom_range(8, 40);
			return;
		end
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 450) :
			$urandom_range(1, 12);
		start <= 1'b0;
		repeat (gap) @(posedge clk);
		burst_left = $urandom_range(0, 6);
	endtask

	// The degree bound only changes once every ok bit has come back and
	// the block has dropped busy.
	task automatic set_bound(logic [DEG_W-1:0] b);
		start <= 1'b0;
		do @(posedge clk); while (ok_due.size() != 0 || busy);
		cfg_we <= 1'b1;
		cfg_data <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		bound_reg = b;
	endtask

	// Removes the newest adds in reverse order to undo them.
	// Positions already undefined, by an earlier remove of an overwritten
	// position or by a stray remove, are skipped.
	task automatic unwind(int depth);
		logic [7:0] pos;
		while (depth > 0 && add_log.size() != 0) begin
			pos = add_log.pop_back();
			depth--;
			if (sb_defined[pos]) begin
				issue_word(KIND_REMOVE, pos, 8'($urandom_range(0, 255)), BY_PREDICTOR);
				pace();
			end
		end
	endtask

	// A well-formed run: the points of a small lattice, all subsets of a
	// few chosen bits on top of a base, get values that are random, nearly
	// constant, affine or affine with one quadratic term. With a zero base
	// every cube of the lattice can complete, so both the difference and
	// the degree tests are reached. Most runs are unwound afterwards.
	task automatic run_lattice();
		logic [7:0] span;
		logic [7:0] base;
		logic [7:0] cst;
		logic [7:0] quad;
		logic [7:0] pos;
		logic [7:0] v;
		logic [7:0] lin [4];
		logic [7:0] spot_pos [16];
		logic [7:0] spot_val [16];
		int dims;
		int cells;
		int used;
		int form;
		int s;
		int b;
		int j;
		int r;
		dims = $urandom_range(1, 4);
		cells = 1 << dims;
		span = 8'd0;
		while ($countones(span) < dims)
			span[$urandom_range(0, 7)] = 1'b1;
		base = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)) & ~span;
		form = $urandom_range(0, 3);
		cst = 8'($urandom_range(0, 255));
		quad = 8'($urandom_range(0, 255));
		for (j = 0; j < 4; j++)
			lin[j] = 8'($urandom_range(0, 255));
		for (s = 0; s < cells; s++) begin
			pos = base;
			j = 0;
			for (b = 0; b < 8; b++) begin
				if (span[b]) begin
					pos[b] = s[j];
					j++;
				end
			end
			v = cst;
			for (j = 0; j < dims; j++)
				if (s[j])
					v = v ^ lin[j];
			if (form == 3 && s[0] && s[1])
				v = v ^ quad;
			if (form == 1)
				v = cst ^ 8'($urandom_range(0, 1));
			if (form == 0)
				v = 8'($urandom_range(0, 255));
			spot_pos[s] = pos;
			spot_val[s] = v;
		end
		// The order of the adds decides where a failing walk stops.
		if ($urandom_range(0, 1)) begin
			for (j = cells - 1; j > 0; j--) begin
				r = $urandom_range(0, j);
				pos = spot_pos[j];
				spot_pos[j] = spot_pos[r];
				spot_pos[r] = pos;
				v = spot_val[j];
				spot_val[j] = spot_val[r];
				spot_val[r] = v;
			end
		end
		used = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cells) : cells;
		for (j = 0; j < used; j++) begin
			issue_word(KIND_ADD, spot_pos[j], spot_val[j], BY_PREDICTOR);
			pace();
		end
		if ($urandom_range(0, 4) != 0)
			unwind(used);
	endtask

	// Noise: fresh random adds, removes at random positions (mostly
	// undefined), and overwrites of positions that are already defined.
	task automatic stir();
		logic [7:0] pos;
		int roll;
		roll = $urandom_range(0, 9);
		pos = 8'($urandom_range(0, 255));
		if (roll < 4) begin
			issue_word(KIND_ADD, pos, 8'($urandom_range(0, 255)), BY_PREDICTOR);
		end else if (roll < 7) begin
			issue_word(KIND_REMOVE, pos, 8'($urandom_range(0, 255)), BY_PREDICTOR);
		end else begin
			if (add_log.size() != 0)
				pos = add_log[$urandom_range(0, add_log.size() - 1)];
			issue_word(KIND_ADD, pos, 8'($urandom_range(0, 255)), BY_PREDICTOR);
		end
		pace();
	endtask

	// Result check. done is a one-cycle strobe and cannot be held off, so
	// every strobe seen at an edge is one result, matched to the oldest ok
	// bit still awaited.
	always @(posedge clk) begin : check_results
		bit due;
		if (arst_n && done) begin
			if (ok_due.size() == 0) begin
				$display("%0t ns: result with none awaited, expected nothing, got ok=%0b",
					$time, ok);
				faults++;
			end else begin
				due = ok_due.pop_front();
				if (ok !== due) begin
					$display("%0t ns: ok mismatch, expected %0b, got %0b", $time, due, ok);
					faults++;
				end
			end
		end
	end

	initial begin : stimulus
		int i;
		int mark;
		row_t row;
		// The local stores start out as the block leaves its clearing pass.
		bound_reg = DEGREE_RESET;
		for (i = 0; i < 256; i++) begin
			sb_value[i] = 8'd0;
			sb_defined[i] = 1'b0;
			cube_tally[i] = 9'd0;
			cube_sum[i] = 8'd0;
		end
		for (i = 0; i < 65536; i++)
			pair_tally[i] = '0;

		// Reset once. The block then clears its stores with busy high, and
		// the first word simply waits for busy to drop.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < $size(PLAN); i++) begin
			row = PLAN[i];
			if (row.act == ROW_BOUND) begin
				set_bound(row.val[DEG_W-1:0]);
			end else begin
				issue_word(row.kind, row.pos, row.val, row.chk);
				pace();
			end
		end
		unwind(add_log.size());

		// Pile-up: with the bound at its top only the full cube is checked,
		// and repeated adds at the top position drive its counter through
		// completion and into saturation; the single remove then steps it
		// back down.
		set_bound(3'd7);
		repeat (PILE_UP_ADDS) begin
			issue_word(KIND_ADD, 8'hff, 8'($urandom_range(0, 255)), BY_PREDICTOR);
			pace();
		end
		unwind(add_log.size());

		// Random phases, each under its own degree bound. Leftover points are
		// unwound before every change so the next phase starts close to clean.
		mark = words_sent;
		set_bound(DEG_W'($urandom_range(0, 7)));
		while (words_sent < WORDS_TOTAL) begin
			if (words_sent - mark >= PHASE_WORDS) begin
				unwind(add_log.size());
				set_bound(DEG_W'($urandom_range(0, 7)));
				mark = words_sent;
			end
			if ($urandom_range(0, 9) < 7)
				run_lattice();
			else
				stir();
			if (add_log.size() > 24)
				unwind(add_log.size());
		end

		// Drain: wait for every awaited ok bit, then keep the clock running so
		// that a stray strobe would still be caught.
		start <= 1'b0;
		do @(posedge clk); while (ok_due.size() != 0);
		repeat (400) @(posedge clk);
		if (faults == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin : watchdog
		#40ms;
		$display("tb: failure");
		$finish;
	end

endmodule
